### hw/rtl/brush_eraser_pixel_kernel_core_defines.svh
// Assertion macros used by the eraser kernel core.
`ifndef BRUSH_ERASER_PIXEL_KERNEL_CORE_DEFINES_SVH
`define BRUSH_ERASER_PIXEL_KERNEL_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define BEPK_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define BEPK_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/bepk_pkg.sv
// Shared constants and types of the eraser pixel kernel.
package bepk_pkg;

  localparam int FRAC_BITS_DEF = 8;

  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 3;
  localparam int OFS_W     = 9;
  localparam int MAG_W     = 9;
  localparam int CH_W      = 8;
  localparam int RADIUS_W  = 8;
  localparam int Q8_W      = 9;
  localparam int Q8_FRAC   = 8;
  localparam int SQ_W      = 17;
  localparam int RSQ_W     = 16;
  localparam int D2_W      = 18;
  localparam int D2_IN_W   = 16;

  localparam int THOUSAND        = 1000;
  localparam int NEAR_ONE_PERMIL = 999;

  localparam logic [Q8_W-1:0] Q8_ONE = Q8_W'(256);

  localparam logic [CFG_IDX_W-1:0] REG_BRUSH_RADIUS   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SHAPE_SQUARE   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ANTI_ALIAS     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_HARDNESS       = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_ERASE_STRENGTH = CFG_IDX_W'(4);

  localparam logic [RADIUS_W-1:0] RADIUS_RST   = RADIUS_W'(8);
  localparam logic                SQUARE_RST   = 1'b0;
  localparam logic                AA_RST       = 1'b1;
  localparam logic [Q8_W-1:0]     HARDNESS_RST = Q8_W'(256);
  localparam logic [Q8_W-1:0]     STRENGTH_RST = Q8_W'(256);

  typedef struct packed {
    logic            write_pixel;
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
    logic [CH_W-1:0] alpha_out;
  } res_t;

endpackage

### hw/rtl/bepk_if.sv
// Pixel input and result output channel interfaces.
interface bepk_pix_if import bepk_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OFS_W-1:0] offset_x;
  logic signed [OFS_W-1:0] offset_y;
  logic [CH_W-1:0]         red_in;
  logic [CH_W-1:0]         green_in;
  logic [CH_W-1:0]         blue_in;
  logic [CH_W-1:0]         alpha_in;

  modport source (output valid, offset_x, offset_y, red_in, green_in, blue_in, alpha_in,
                  input ready);
  modport sink (input valid, offset_x, offset_y, red_in, green_in, blue_in, alpha_in,
                output ready);
endinterface

interface bepk_res_if import bepk_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            write_pixel;
  logic [CH_W-1:0] red_out;
  logic [CH_W-1:0] green_out;
  logic [CH_W-1:0] blue_out;
  logic [CH_W-1:0] alpha_out;

  modport source (output valid, write_pixel, red_out, green_out, blue_out, alpha_out,
                  input ready);
  modport sink (input valid, write_pixel, red_out, green_out, blue_out, alpha_out,
                output ready);
endinterface

### hw/rtl/brush_eraser_pixel_kernel_core.sv
// Top level of the soft-edged eraser dab pixel kernel.
//
// Feed one dab pixel per beat on pix: its signed offset from the dab center
// and its RGBA value. Each pixel gives exactly one beat on res, in order:
// write_pixel and the four channels scaled by one minus the falloff strength
// times the erase strength (unchanged channels when write_pixel is low).
// Registers (radius, shape, anti-alias, hardness, erase strength) are written
// through cfg_wr_en / cfg_index / cfg_data; the user must do so only while no
// pixel is in flight, which the block does not enforce. Throughput: one pixel
// per cycle while res does not stall. A pixel passes the magnitude, square and
// circle test stages, the square-root pipeline (one root bit per stage), the
// two dividers (one quotient bit per stage), and falloff and scale stages.
// Reset clears all valid bits and loads the register defaults (radius 8,
// round brush, anti-alias on, hardness and erase strength at one).
// When res stalls, the output register holds and one more beat goes into a
// skid entry; pix.ready then drops and the whole pipeline holds in place.
`include "brush_eraser_pixel_kernel_core_defines.svh"

module brush_eraser_pixel_kernel_core import bepk_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  bepk_pix_if.sink             pix,
  bepk_res_if.source           res
);

  localparam int RAD_W  = D2_IN_W + 2 * FRAC_BITS;
  localparam int ROOT_W = RAD_W / 2;
  localparam int NUM1_W = MAG_W + FRAC_BITS;
  localparam int Q_W    = FRAC_BITS + 1;
  localparam int NUM2_W = 2 * FRAC_BITS + 1;
  localparam int PROD_W = 2 * FRAC_BITS + 2;
  localparam int PM_W   = FRAC_BITS + 11;
  localparam int SC_W   = FRAC_BITS + CH_W + 1;

  localparam logic [FRAC_BITS:0] ONE_Q  = Q_W'(1) << FRAC_BITS;
  localparam logic [FRAC_BITS:0] HALF_Q = ONE_Q >> 1;
  localparam logic [PM_W-1:0] NEAR_ONE_X1000 = PM_W'(NEAR_ONE_PERMIL) << FRAC_BITS;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
  } chan_t;

  typedef struct packed {
    logic             in_dab;
    logic [MAG_W-1:0] cheb;
    chan_t            ch;
  } sqrt_side_t;

  typedef struct packed {
    logic  in_dab;
    chan_t ch;
  } dist_side_t;

  typedef struct packed {
    logic  ok;
    logic  soft_en;
    logic  keep;
    chan_t ch;
  } soft_side_t;

  function automatic logic [MAG_W-1:0] mag_of(input logic [OFS_W-1:0] v);
    return v[OFS_W-1] ? MAG_W'(~v + 1'b1) : MAG_W'(v);
  endfunction

  function automatic logic [FRAC_BITS:0] q8_to_q(input logic [Q8_W-1:0] v);
    logic [Q8_W-1:0]           sat;
    logic [Q8_W+FRAC_BITS-1:0] wide;
    sat  = (v > Q8_ONE) ? Q8_ONE : v;
    wide = {sat, {FRAC_BITS{1'b0}}};
    return wide[Q8_FRAC+FRAC_BITS:Q8_FRAC];
  endfunction

  function automatic logic [CH_W-1:0] scale_ch(input logic [CH_W-1:0] c,
                                               input logic [FRAC_BITS:0] k);
    logic [SC_W-1:0] p;
    p = SC_W'(c) * SC_W'(k) + SC_W'(HALF_Q);
    return p[FRAC_BITS+CH_W-1:FRAC_BITS];
  endfunction

  // ---------------- configuration registers ----------------
  logic [RADIUS_W-1:0] radius;
  logic                shape_square;
  logic                anti_alias;
  logic [Q8_W-1:0]     hardness;
  logic [Q8_W-1:0]     erase_strength;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius         <= RADIUS_RST;
      shape_square   <= SQUARE_RST;
      anti_alias     <= AA_RST;
      hardness       <= HARDNESS_RST;
      erase_strength <= STRENGTH_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_BRUSH_RADIUS:   radius         <= cfg_data[RADIUS_W-1:0];
        REG_SHAPE_SQUARE:   shape_square   <= cfg_data[0];
        REG_ANTI_ALIAS:     anti_alias     <= cfg_data[0];
        REG_HARDNESS:       hardness       <= cfg_data[Q8_W-1:0];
        REG_ERASE_STRENGTH: erase_strength <= cfg_data[Q8_W-1:0];
        default: ;
      endcase
    end
  end

  logic [FRAC_BITS:0]  hard_q;
  logic [FRAC_BITS:0]  es_q;
  logic                hard_soft_ok;
  logic [RADIUS_W-1:0] rdiv;

  assign hard_q       = q8_to_q(hardness);
  assign es_q         = q8_to_q(erase_strength);
  // soft falloff only while hardness is below 0.999
  assign hard_soft_ok = PM_W'(hard_q) * PM_W'(THOUSAND) < NEAR_ONE_X1000;
  assign rdiv         = (radius == '0) ? RADIUS_W'(1) : radius;

  logic adv;

  assign pix.ready = adv;

  // ---------------- stage A: magnitudes ----------------
  logic             a_valid;
  logic [MAG_W-1:0] a_ax;
  logic [MAG_W-1:0] a_ay;
  chan_t            a_ch;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_ax <= mag_of(pix.offset_x);
      a_ay <= mag_of(pix.offset_y);
      a_ch <= '{red: pix.red_in, green: pix.green_in, blue: pix.blue_in,
                alpha: pix.alpha_in};
    end
  end

  // ---------------- stage B: squares, Chebyshev distance ----------------
  logic             b_valid;
  logic [SQ_W-1:0]  b_sqx;
  logic [SQ_W-1:0]  b_sqy;
  logic [RSQ_W-1:0] b_rsq;
  logic [MAG_W-1:0] b_cheb;
  chan_t            b_ch;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_sqx  <= SQ_W'(a_ax) * SQ_W'(a_ax);
      b_sqy  <= SQ_W'(a_ay) * SQ_W'(a_ay);
      b_rsq  <= RSQ_W'(radius) * RSQ_W'(radius);
      b_cheb <= (a_ax > a_ay) ? a_ax : a_ay;
      b_ch   <= a_ch;
    end
  end

  // ---------------- stage C: inside test ----------------
  logic               c_valid;
  logic               c_inside;
  logic [D2_IN_W-1:0] c_rad;
  logic [MAG_W-1:0]   c_cheb;
  chan_t              c_ch;
  logic [D2_W-1:0]    b_d2;

  assign b_d2 = D2_W'(b_sqx) + D2_W'(b_sqy);

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_inside <= shape_square ? (b_cheb <= MAG_W'(radius)) : (b_d2 <= D2_W'(b_rsq));
      // inside a round dab d2 <= 255*255, so the low bits are enough
      c_rad    <= b_d2[D2_IN_W-1:0];
      c_cheb   <= b_cheb;
      c_ch     <= b_ch;
    end
  end

  // ---------------- square root ----------------
  logic              sq_valid;
  logic [ROOT_W-1:0] sq_root;
  sqrt_side_t        sq_side_in;
  sqrt_side_t        sq_side;

  assign sq_side_in = '{in_dab: c_inside, cheb: c_cheb, ch: c_ch};

  bepk_sqrt_pipe #(
    .RAD_W  (RAD_W),
    .SIDE_W ($bits(sqrt_side_t))
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (c_valid),
    .in_rad    ({c_rad, {(2 * FRAC_BITS){1'b0}}}),
    .in_side   (sq_side_in),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // ---------------- distance divider ----------------
  logic [NUM1_W-1:0] dv1_num;
  dist_side_t        dv1_side_in;
  logic              dv1_valid;
  logic [Q_W-1:0]    dab_dist;
  dist_side_t        dv1_side;

  assign dv1_num     = shape_square ? {sq_side.cheb, {FRAC_BITS{1'b0}}} : NUM1_W'(sq_root);
  assign dv1_side_in = '{in_dab: sq_side.in_dab, ch: sq_side.ch};

  bepk_div_pipe #(
    .NUM_W  (NUM1_W),
    .DEN_W  (RADIUS_W),
    .Q_W    (Q_W),
    .SIDE_W ($bits(dist_side_t))
  ) u_div_dist (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (sq_valid),
    .in_num    (dv1_num),
    .in_den    (rdiv),
    .in_side   (dv1_side_in),
    .out_valid (dv1_valid),
    .out_quo   (dab_dist),
    .out_side  (dv1_side)
  );

  // ---------------- stage D: falloff setup ----------------
  logic              d_valid;
  logic [NUM2_W-1:0] d_num;
  logic [Q_W-1:0]    d_den;
  soft_side_t        d_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (adv) begin
      d_valid <= dv1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_num  <= {dab_dist - hard_q, {FRAC_BITS{1'b0}}};
      d_den  <= ONE_Q - hard_q;
      d_side <= '{ok:      dv1_side.in_dab && (dab_dist <= ONE_Q),
                  soft_en: hard_soft_ok && (dab_dist > hard_q),
                  keep:    dab_dist <= hard_q,
                  ch:      dv1_side.ch};
    end
  end

  // ---------------- falloff divider ----------------
  logic           dv2_valid;
  logic [Q_W-1:0] fall;
  soft_side_t     dv2_side;

  bepk_div_pipe #(
    .NUM_W  (NUM2_W),
    .DEN_W  (Q_W),
    .Q_W    (Q_W),
    .SIDE_W ($bits(soft_side_t))
  ) u_div_fall (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (d_valid),
    .in_num    (d_num),
    .in_den    (d_den),
    .in_side   (d_side),
    .out_valid (dv2_valid),
    .out_quo   (fall),
    .out_side  (dv2_side)
  );

  // ---------------- stage E: strength times erase strength ----------------
  logic               e_valid;
  logic               e_ok;
  logic [PROD_W-1:0]  e_prod;
  chan_t              e_ch;
  logic [FRAC_BITS:0] str;

  always_comb begin
    if (anti_alias) begin
      str = dv2_side.soft_en ? ONE_Q - fall : ONE_Q;
    end else begin
      str = dv2_side.keep ? ONE_Q : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (adv) begin
      e_valid <= dv2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_prod <= PROD_W'(str) * PROD_W'(es_q);
      e_ok   <= dv2_side.ok;
      e_ch   <= dv2_side.ch;
    end
  end

  // ---------------- stage F: round, clamp, write flag ----------------
  logic               f_valid;
  logic               f_write;
  logic [FRAC_BITS:0] f_s;
  chan_t              f_ch;
  logic [PROD_W-1:0]  e_rnd;
  logic [FRAC_BITS+1:0] e_s_wide;
  logic [FRAC_BITS:0] e_s;

  assign e_rnd    = e_prod + PROD_W'(HALF_Q);
  assign e_s_wide = e_rnd[PROD_W-1:FRAC_BITS];
  assign e_s      = (e_s_wide > (FRAC_BITS + 2)'(ONE_Q)) ? ONE_Q : e_s_wide[FRAC_BITS:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (adv) begin
      f_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // written only when strength is above 0.001
      f_write <= e_ok && (PM_W'(e_s) * PM_W'(THOUSAND) > PM_W'(ONE_Q));
      f_s     <= e_s;
      f_ch    <= e_ch;
    end
  end

  // ---------------- stage G: channel scaling ----------------
  logic               g_valid;
  res_t               g_res;
  logic [FRAC_BITS:0] keep_k;

  assign keep_k = ONE_Q - f_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
    end else if (adv) begin
      g_valid <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_res.write_pixel <= f_write;
      g_res.red_out     <= f_write ? scale_ch(f_ch.red, keep_k) : f_ch.red;
      g_res.green_out   <= f_write ? scale_ch(f_ch.green, keep_k) : f_ch.green;
      g_res.blue_out    <= f_write ? scale_ch(f_ch.blue, keep_k) : f_ch.blue;
      g_res.alpha_out   <= f_write ? scale_ch(f_ch.alpha, keep_k) : f_ch.alpha;
    end
  end

  bepk_skid u_skid (
    .clk      (clk),
    .rst      (rst),
    .up_valid (g_valid),
    .up_data  (g_res),
    .up_ready (adv),
    .res      (res)
  );

  // ---------------- assertions ----------------
  `BEPK_ASSERT_NOW(a_frozen_has_output, !pix.ready, res.valid, "pipeline held with no output beat")
  `BEPK_ASSERT_NEXT(a_skid_holds, res.valid && !res.ready && !pix.ready, !pix.ready, "skid entry dropped during stall")
  `BEPK_ASSERT_NOW(a_write_has_strength, f_valid && f_write, f_s != '0, "write flag with zero strength")

endmodule

### hw/rtl/bepk_sqrt_pipe.sv
// Pipelined integer square root, one root bit per register stage.
module bepk_sqrt_pipe import bepk_pkg::*; #(
  parameter int RAD_W  = D2_IN_W + 2 * FRAC_BITS_DEF,
  parameter int SIDE_W = 1,
  localparam int RES_W = RAD_W / 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [RAD_W-1:0]  in_rad,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [RES_W-1:0]  out_root,
  output logic [SIDE_W-1:0] out_side
);

  localparam int RM_W = RES_W + 2;

  logic [RM_W-1:0]   rem      [RES_W];
  logic [RES_W-1:0]  root     [RES_W];
  logic [RAD_W-1:0]  rad      [RES_W];
  logic [SIDE_W-1:0] side     [RES_W];
  logic [RES_W-1:0]  vld;

  logic [RM_W-1:0]   rem_next [RES_W];
  logic [RES_W-1:0]  root_next[RES_W];
  logic [RAD_W-1:0]  rad_next [RES_W];

  logic [RM_W-1:0]   rem_p;
  logic [RES_W-1:0]  root_p;
  logic [RAD_W-1:0]  rad_p;
  logic [RM_W-1:0]   cand;
  logic [RM_W-1:0]   test;
  logic              take;

  always_comb begin
    for (int k = 0; k < RES_W; k++) begin
      if (k == 0) begin
        rem_p  = '0;
        root_p = '0;
        rad_p  = in_rad;
      end else begin
        rem_p  = rem[k-1];
        root_p = root[k-1];
        rad_p  = rad[k-1];
      end
      // bring down the next two radicand bits, try (4*root + 1)
      cand         = {rem_p[RM_W-3:0], rad_p[RAD_W-1 -: 2]};
      test         = {root_p, 2'b01};
      take         = cand >= test;
      rem_next[k]  = take ? cand - test : cand;
      root_next[k] = {root_p[RES_W-2:0], take};
      rad_next[k]  = rad_p << 2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[RES_W-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= in_side;
      for (int k = 0; k < RES_W; k++) begin
        rem[k]  <= rem_next[k];
        root[k] <= root_next[k];
        rad[k]  <= rad_next[k];
      end
      for (int k = 1; k < RES_W; k++) begin
        side[k] <= side[k-1];
      end
    end
  end

  assign out_valid = vld[RES_W-1];
  assign out_root  = root[RES_W-1];
  assign out_side  = side[RES_W-1];

endmodule

### hw/rtl/bepk_div_pipe.sv
// Pipelined restoring divider, one quotient bit per register stage.
module bepk_div_pipe import bepk_pkg::*; #(
  parameter int NUM_W  = MAG_W + FRAC_BITS_DEF,
  parameter int DEN_W  = RADIUS_W,
  parameter int Q_W    = FRAC_BITS_DEF + 1,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [Q_W-1:0]    out_quo,
  output logic [SIDE_W-1:0] out_side
);

  // quotient is assumed to fit in Q_W bits: num < den << Q_W
  localparam int CMP_W = NUM_W + DEN_W + Q_W;

  logic [NUM_W-1:0]  rem      [Q_W];
  logic [Q_W-1:0]    quo      [Q_W];
  logic [DEN_W-1:0]  den      [Q_W];
  logic [SIDE_W-1:0] side     [Q_W];
  logic [Q_W-1:0]    vld;

  logic [NUM_W-1:0]  rem_next [Q_W];
  logic [Q_W-1:0]    quo_next [Q_W];

  logic [NUM_W-1:0]  rem_p;
  logic [Q_W-1:0]    quo_p;
  logic [DEN_W-1:0]  den_p;
  logic [CMP_W-1:0]  trial;
  logic              take;

  always_comb begin
    for (int j = 0; j < Q_W; j++) begin
      if (j == 0) begin
        rem_p = in_num;
        quo_p = '0;
        den_p = in_den;
      end else begin
        rem_p = rem[j-1];
        quo_p = quo[j-1];
        den_p = den[j-1];
      end
      trial       = CMP_W'(den_p) << (Q_W - 1 - j);
      take        = CMP_W'(rem_p) >= trial;
      rem_next[j] = take ? NUM_W'(CMP_W'(rem_p) - trial) : rem_p;
      quo_next[j] = quo_p;
      quo_next[j][Q_W-1-j] = take;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Q_W-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den[0]  <= in_den;
      side[0] <= in_side;
      for (int j = 0; j < Q_W; j++) begin
        rem[j]  <= rem_next[j];
        quo[j]  <= quo_next[j];
      end
      for (int j = 1; j < Q_W; j++) begin
        den[j]  <= den[j-1];
        side[j] <= side[j-1];
      end
    end
  end

  assign out_valid = vld[Q_W-1];
  assign out_quo   = quo[Q_W-1];
  assign out_side  = side[Q_W-1];

endmodule

### hw/rtl/bepk_skid.sv
// Output register with one skid entry; decouples pipeline advance from res.ready.
module bepk_skid import bepk_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       up_valid,
  input  res_t       up_data,
  output logic       up_ready,
  bepk_res_if.source res
);

  logic out_valid;
  res_t out_data;
  logic skid_valid;
  res_t skid_data;
  logic drain;

  assign drain    = !out_valid || res.ready;
  assign up_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (drain) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= up_valid;
      end
    end else if (up_valid && !skid_valid) begin
      // output is stalled: park the incoming beat
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      out_data <= skid_valid ? skid_data : up_data;
    end else if (!skid_valid) begin
      skid_data <= up_data;
    end
  end

  assign res.valid       = out_valid;
  assign res.write_pixel = out_data.write_pixel;
  assign res.red_out     = out_data.red_out;
  assign res.green_out   = out_data.green_out;
  assign res.blue_out    = out_data.blue_out;
  assign res.alpha_out   = out_data.alpha_out;

endmodule
